@@ rtl/core/mtb_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtb_pkg
// Shared types and sizes for the mean threshold binarizer.
// ----------------------------------------------------------------------------
package mtb_pkg;

    localparam int MAX_WIDTH   = 256;
    localparam int MAX_HEIGHT  = 256;
    localparam int STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int COUNT_W     = $clog2(STORE_DEPTH + 1);
    localparam int PIX_W       = 8;
    localparam int SUM_W       = PIX_W + ADDR_W;
    localparam int DIM_W       = 9;
    localparam int DIV_CNT_W   = $clog2(SUM_W);
    localparam int CFG_IDX_W   = 1;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FRAME_WIDTH  = 1'b0,
        CFG_FRAME_HEIGHT = 1'b1
    } t_cfg_idx;

    // Command kinds after classification
    typedef enum logic [0:0] {
        OP_LOAD = 1'b0,
        OP_READ = 1'b1
    } t_op;

    typedef struct packed {
        logic             action;
        logic [PIX_W-1:0] pixel_value;
    } t_in;

    typedef struct packed {
        logic bilevel_bit;
        logic last_bit;
        logic status;
    } t_out;

    typedef struct packed {
        t_op              op;
        logic [PIX_W-1:0] pixel;
    } t_cmd;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    typedef struct packed {
        logic               start;
        logic [SUM_W-1:0]   dividend;
        logic [COUNT_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [PIX_W-1:0] quotient;
    } t_div_rsp;

endpackage

@@ rtl/core/mtb_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtb_front
// Input stage: accepts beats, classifies them into load or read commands and
// hands them to the command queue.
// ----------------------------------------------------------------------------
module mtb_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  mtb_pkg::t_in        i_data,
    input  mtb_pkg::t_q_status  i_q_status,
    output logic                o_push,
    output mtb_pkg::t_cmd       o_cmd
);

    logic          r_valid;
    mtb_pkg::t_cmd r_cmd;
    mtb_pkg::t_cmd n_cmd;
    logic          accept;

    // Classify the incoming beat
    always_comb begin
        n_cmd.op    = i_data.action ? mtb_pkg::OP_READ : mtb_pkg::OP_LOAD;
        n_cmd.pixel = i_data.pixel_value;
    end

    assign o_stall = r_valid && i_q_status.full;
    assign accept  = i_valid && !o_stall;

    // Hold one command until the queue takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (!i_q_status.full) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd <= n_cmd;
        end
    end

    assign o_push = r_valid;
    assign o_cmd  = r_cmd;

endmodule

@@ rtl/core/mtb_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtb_queue
// Two-entry command queue between the front and the back.
// ----------------------------------------------------------------------------
module mtb_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  mtb_pkg::t_cmd       i_cmd,
    input  logic                i_pop,
    output mtb_pkg::t_cmd       o_cmd,
    output mtb_pkg::t_q_status  o_status
);

    mtb_pkg::t_cmd r_slot [2];
    logic          r_wr_ptr;
    logic          r_rd_ptr;
    logic [1:0]    r_count;
    logic          do_push;
    logic          do_pop;

    assign o_status.full  = (r_count == 2'd2);
    assign o_status.empty = (r_count == 2'd0);
    assign do_push = i_push && !o_status.full;
    assign do_pop  = i_pop && !o_status.empty;
    assign o_cmd   = r_slot[r_rd_ptr];

    // Advance pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (do_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 2'd1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

@@ rtl/core/mtb_div.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtb_div
// Restoring divider: pixel sum over pixel count, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module mtb_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  mtb_pkg::t_div_req i_req,
    output mtb_pkg::t_div_rsp o_rsp
);

    logic                               r_busy;
    logic                               r_done;
    logic [mtb_pkg::DIV_CNT_W-1:0]      r_cnt;
    logic [mtb_pkg::SUM_W-1:0]          r_quo;
    logic [mtb_pkg::COUNT_W-1:0]        r_rem;
    logic [mtb_pkg::COUNT_W-1:0]        r_dsr;
    logic [mtb_pkg::COUNT_W:0]          trial;
    logic                               fits;
    logic [mtb_pkg::COUNT_W-1:0]        n_rem;

    // One restoring step
    always_comb begin
        trial = {r_rem, r_quo[mtb_pkg::SUM_W-1]};
        fits  = (trial >= {1'b0, r_dsr});
        if (fits) begin
            n_rem = mtb_pkg::COUNT_W'(trial - {1'b0, r_dsr});
        end else begin
            n_rem = trial[mtb_pkg::COUNT_W-1:0];
        end
    end

    // Control: count steps, pulse done after the last one
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == mtb_pkg::DIV_CNT_W'(mtb_pkg::SUM_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath: shift the quotient in behind the dividend
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_quo <= i_req.dividend;
            r_rem <= '0;
            r_dsr <= i_req.divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[mtb_pkg::SUM_W-2:0], fits};
            r_rem <= n_rem;
        end
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quo[mtb_pkg::PIX_W-1:0];

endmodule

@@ rtl/core/mtb_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtb_back
// Execution side: stores and sums pixels, runs the mean division, reads the
// frame back against the mean and drives the result register.
// ----------------------------------------------------------------------------
module mtb_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [mtb_pkg::COUNT_W-1:0]   i_frame_size,
    input  mtb_pkg::t_cmd                 i_cmd,
    input  mtb_pkg::t_q_status            i_q_status,
    output logic                          o_pop,
    output logic                          o_valid,
    input  logic                          i_stall,
    output mtb_pkg::t_out                 o_data
);

    typedef enum logic [0:0] {
        ST_RUN = 1'b0,
        ST_DIV = 1'b1
    } t_state;

    t_state                         r_state;
    logic [mtb_pkg::SUM_W-1:0]      r_sum;
    logic [mtb_pkg::COUNT_W-1:0]    r_load_count;
    logic [mtb_pkg::COUNT_W-1:0]    r_read_count;
    logic [mtb_pkg::PIX_W-1:0]      r_mean;
    logic                           r_full;

    logic                           r_pend;
    logic                           r_pend_early;
    logic                           r_pend_last;
    logic [mtb_pkg::PIX_W-1:0]      r_pend_mean;
    logic [mtb_pkg::PIX_W-1:0]      r_rd_data;

    logic                           r_out_valid;
    mtb_pkg::t_out                  r_out;

    logic [mtb_pkg::PIX_W-1:0]      r_store [mtb_pkg::STORE_DEPTH];

    logic                           can_read;
    logic                           pop_load;
    logic                           pop_read;
    logic [mtb_pkg::SUM_W-1:0]      n_sum;
    logic [mtb_pkg::COUNT_W-1:0]    n_load_count;
    logic [mtb_pkg::COUNT_W-1:0]    n_read_count;
    logic                           n_last;
    mtb_pkg::t_out                  n_out;
    mtb_pkg::t_div_req              div_req;
    mtb_pkg::t_div_rsp              div_rsp;

    // Issue: a read needs no read pending and the result register free or unstalled
    assign can_read = !r_pend && (!r_out_valid || !i_stall);
    always_comb begin
        pop_load = 1'b0;
        pop_read = 1'b0;
        if (r_state == ST_RUN && !i_q_status.empty) begin
            unique case (i_cmd.op)
                mtb_pkg::OP_LOAD: pop_load = 1'b1;
                mtb_pkg::OP_READ: pop_read = can_read;
                default:          pop_load = 1'b0;
            endcase
        end
    end
    assign o_pop = pop_load || pop_read;

    // Next counts and sum
    assign n_sum        = r_sum + mtb_pkg::SUM_W'(i_cmd.pixel);
    assign n_load_count = r_load_count + 1'b1;
    assign n_read_count = r_read_count + 1'b1;
    assign n_last       = (n_read_count == r_load_count);

    // Start the mean division on the last pixel of the frame
    always_comb begin
        div_req.start    = pop_load && !r_full && (n_load_count >= i_frame_size);
        div_req.dividend = n_sum;
        div_req.divisor  = n_load_count;
    end

    mtb_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    // Frame state and sequencing
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_RUN;
            r_sum        <= '0;
            r_load_count <= '0;
            r_read_count <= '0;
            r_mean       <= '0;
            r_full       <= 1'b0;
            r_pend       <= 1'b0;
        end else begin
            r_pend <= pop_read;
            unique case (r_state)
                ST_RUN: begin
                    if (pop_load && !r_full) begin
                        r_sum        <= n_sum;
                        r_load_count <= n_load_count;
                        if (div_req.start) begin
                            r_state <= ST_DIV;
                        end
                    end else if (pop_read && r_full) begin
                        if (n_last) begin
                            r_sum        <= '0;
                            r_load_count <= '0;
                            r_read_count <= '0;
                            r_mean       <= '0;
                            r_full       <= 1'b0;
                        end else begin
                            r_read_count <= n_read_count;
                        end
                    end
                end
                ST_DIV: begin
                    if (div_rsp.done) begin
                        r_mean  <= div_rsp.quotient;
                        r_full  <= 1'b1;
                        r_state <= ST_RUN;
                    end
                end
                default: r_state <= ST_RUN;
            endcase
        end
    end

    // Capture what the pending read needs
    always_ff @(posedge i_clk) begin
        if (pop_read) begin
            r_pend_early <= !r_full;
            r_pend_last  <= n_last;
            r_pend_mean  <= r_mean;
        end
    end

    // Pixel store: write on load, registered read on readout
    always_ff @(posedge i_clk) begin
        if (pop_load && !r_full) begin
            r_store[r_load_count[mtb_pkg::ADDR_W-1:0]] <= i_cmd.pixel;
        end
        if (pop_read) begin
            r_rd_data <= r_store[r_read_count[mtb_pkg::ADDR_W-1:0]];
        end
    end

    // Threshold the pixel against the mean; an early read gives status 1
    always_comb begin
        if (r_pend_early) begin
            n_out.bilevel_bit = 1'b0;
            n_out.last_bit    = 1'b0;
            n_out.status      = 1'b1;
        end else begin
            n_out.bilevel_bit = (r_rd_data > r_pend_mean) ? 1'b0 : 1'b1;
            n_out.last_bit    = r_pend_last;
            n_out.status      = 1'b0;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_pend) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_pend) begin
            r_out <= n_out;
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out;

endmodule

@@ rtl/core/mean_threshold_binarizer_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mean_threshold_binarizer_core
// Global mean threshold binarizer: loads a greyscale frame, then reads it
// back as one bilevel bit per pixel against the frame's mean grey level.
// ----------------------------------------------------------------------------
// Input channel (i_in_valid / o_in_stall / i_in_data): each beat is either a
// pixel load (action 0) or a readout request (action 1). Output channel
// (o_out_valid / i_out_stall / o_out_data) carries one beat per readout
// request and none per load. Frame size is set through i_cfg_we / i_cfg_idx /
// i_cfg_data (width, then height), sizes of 0 act as 1, sizes above 256 as 256.
// Loads are taken at one per cycle while the queue has room. After the last
// pixel of a frame the serial divider computing the mean holds the back end
// until it is done; the front and the queue buffer what arrives meanwhile
// until they are full. A readout passes the front register, the queue, the
// pixel store's registered read and the single result register; a new one
// issues only with no read pending and the result register free or unstalled.
// Reading before the frame is complete returns status 1; loads while a full
// frame waits are dropped; the bit marked last empties the block.
// Reset (synchronous, active low) empties the queue and frame, sets the size
// to 256 x 256; the pixel store needs no clearing. A stall on the output
// holds the result beat and backs up through a two-entry queue to o_in_stall.
// ----------------------------------------------------------------------------
module mean_threshold_binarizer_core (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  mtb_pkg::t_in                       i_in_data,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output mtb_pkg::t_out                      o_out_data,
    input  logic                               i_cfg_we,
    input  logic [mtb_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [mtb_pkg::DIM_W-1:0]          i_cfg_data
);

    logic [mtb_pkg::DIM_W-1:0]      r_frame_width;
    logic [mtb_pkg::DIM_W-1:0]      r_frame_height;
    logic [mtb_pkg::DIM_W-1:0]      width_eff;
    logic [mtb_pkg::DIM_W-1:0]      height_eff;
    logic [2*mtb_pkg::DIM_W-1:0]    size_prod;
    logic [mtb_pkg::COUNT_W-1:0]    frame_size;

    logic                           push;
    logic                           pop;
    mtb_pkg::t_cmd                  front_cmd;
    mtb_pkg::t_cmd                  queue_cmd;
    mtb_pkg::t_q_status             q_status;

    function automatic logic [mtb_pkg::DIM_W-1:0] clamp_dim(
        input logic [mtb_pkg::DIM_W-1:0] value,
        input logic [mtb_pkg::DIM_W-1:0] limit
    );
        logic [mtb_pkg::DIM_W-1:0] res;
        if (value == '0) begin
            res = mtb_pkg::DIM_W'(1);
        end else if (value > limit) begin
            res = limit;
        end else begin
            res = value;
        end
        return res;
    endfunction

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= mtb_pkg::DIM_W'(256);
            r_frame_height <= mtb_pkg::DIM_W'(256);
        end else if (i_cfg_we) begin
            unique case (mtb_pkg::t_cfg_idx'(i_cfg_idx))
                mtb_pkg::CFG_FRAME_WIDTH:  r_frame_width  <= i_cfg_data;
                mtb_pkg::CFG_FRAME_HEIGHT: r_frame_height <= i_cfg_data;
                default:                   r_frame_width  <= r_frame_width;
            endcase
        end
    end

    // Effective frame size in pixels
    assign width_eff  = clamp_dim(r_frame_width, mtb_pkg::DIM_W'(mtb_pkg::MAX_WIDTH));
    assign height_eff = clamp_dim(r_frame_height, mtb_pkg::DIM_W'(mtb_pkg::MAX_HEIGHT));
    assign size_prod  = width_eff * height_eff;
    assign frame_size = size_prod[mtb_pkg::COUNT_W-1:0];

    mtb_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_in_valid),
        .o_stall    (o_in_stall),
        .i_data     (i_in_data),
        .i_q_status (q_status),
        .o_push     (push),
        .o_cmd      (front_cmd)
    );

    mtb_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_cmd    (front_cmd),
        .i_pop    (pop),
        .o_cmd    (queue_cmd),
        .o_status (q_status)
    );

    mtb_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_frame_size (frame_size),
        .i_cmd        (queue_cmd),
        .i_q_status   (q_status),
        .o_pop        (pop),
        .o_valid      (o_out_valid),
        .i_stall      (i_out_stall),
        .o_data       (o_out_data)
    );

endmodule

@@ tb/tb_mean_threshold_binarizer_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_mean_threshold_binarizer_core
// Self-checking bench for the mean threshold binarizer. A scoreboard keeps its
// own copy of the frame store, sum and counters, predicts one readout beat per
// accepted read request, and compares every output beat field by field. The
// stimulus starts a frame at the reset size and shrinks it below the loaded
// count, runs a few directed frames for the size corner cases, then random
// small frames with early readouts, dropped loads and size changes in the
// middle of loading and readout. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module tb_mean_threshold_binarizer_core;
    import mtb_pkg::*;

    localparam int RANDOM_BEATS = 400;
    localparam int SETTLE_CYCLES = 40;

    // Scoreboard: tracks the frame the block should hold and the readout beats
    // it owes, in order.
    class binarizer_scoreboard;
        logic [DIM_W-1:0]   width_reg;
        logic [DIM_W-1:0]   height_reg;
        bit   [PIX_W-1:0]   pixel_mem [STORE_DEPTH];
        logic [SUM_W-1:0]   pixel_sum;
        logic [COUNT_W-1:0] load_count;
        logic [COUNT_W-1:0] read_count;
        logic [PIX_W-1:0]   mean_level;
        bit                 frame_full;
        t_out               pending_bits [$];
        int                 errors;

        function new();
            width_reg  = DIM_W'(256);
            height_reg = DIM_W'(256);
            errors     = 0;
            clear_frame();
        endfunction

        function void clear_frame();
            pixel_sum  = '0;
            load_count = '0;
            read_count = '0;
            mean_level = '0;
            frame_full = 1'b0;
        endfunction

        function void write_reg(t_cfg_idx idx, logic [DIM_W-1:0] value);
            if (idx == CFG_FRAME_WIDTH) begin
                width_reg = value;
            end else begin
                height_reg = value;
            end
        endfunction

        // Zero acts as one, anything above the maximum acts as the maximum
        function int unsigned clamp_dim(logic [DIM_W-1:0] value, int unsigned limit);
            if (value == 0) begin
                return 1;
            end
            if (value > limit) begin
                return limit;
            end
            return value;
        endfunction

        function int unsigned frame_pixels();
            return clamp_dim(width_reg, MAX_WIDTH) * clamp_dim(height_reg, MAX_HEIGHT);
        endfunction

        function void note_beat(t_in beat);
            t_out exp_bit;
            // Load: drop while a complete frame waits, close the frame on the last pixel
            if (beat.action == OP_LOAD) begin
                if (frame_full) begin
                    return;
                end
                if (load_count < STORE_DEPTH) begin
                    pixel_mem[load_count] = beat.pixel_value;
                    pixel_sum  = pixel_sum + beat.pixel_value;
                    load_count = load_count + 1'b1;
                end
                if (load_count >= frame_pixels() || load_count >= STORE_DEPTH) begin
                    mean_level = PIX_W'(pixel_sum / load_count);
                    frame_full = 1'b1;
                end
                return;
            end
            // Readout before the frame is complete reports not-ready
            if (!frame_full || read_count >= load_count) begin
                exp_bit.bilevel_bit = 1'b0;
                exp_bit.last_bit    = 1'b0;
                exp_bit.status      = 1'b1;
                pending_bits.push_back(exp_bit);
                return;
            end
            exp_bit.bilevel_bit = (pixel_mem[read_count] > mean_level) ? 1'b0 : 1'b1;
            read_count          = read_count + 1'b1;
            exp_bit.last_bit    = (read_count >= load_count);
            exp_bit.status      = 1'b0;
            pending_bits.push_back(exp_bit);
            if (exp_bit.last_bit) begin
                clear_frame();
            end
        endfunction

        function void flag_error(string msg);
            errors++;
            if (errors <= 10) begin
                $display("%0t: %s", $time, msg);
            end
        endfunction

        function void check_beat(t_out got);
            t_out exp_bit;
            if (pending_bits.size() == 0) begin
                flag_error($sformatf("unexpected readout beat bit=%0b last=%0b status=%0b",
                                     got.bilevel_bit, got.last_bit, got.status));
                return;
            end
            exp_bit = pending_bits.pop_front();
            if (got.bilevel_bit !== exp_bit.bilevel_bit || got.last_bit !== exp_bit.last_bit
                    || got.status !== exp_bit.status) begin
                flag_error($sformatf({"readout mismatch: expected bit=%0b last=%0b status=%0b,",
                                      " got bit=%0b last=%0b status=%0b"},
                                     exp_bit.bilevel_bit, exp_bit.last_bit, exp_bit.status,
                                     got.bilevel_bit, got.last_bit, got.status));
            end
        endfunction
    endclass

    logic               i_clk;
    logic               i_rst_n;
    logic               in_valid;
    logic               o_in_stall;
    t_in                in_data;
    logic               o_out_valid;
    logic               out_stall;
    t_out               o_out_data;
    logic               cfg_we;
    logic [CFG_IDX_W-1:0] cfg_idx;
    logic [DIM_W-1:0]   cfg_data;

    binarizer_scoreboard sb;
    bit                 idle_on;
    int                 beat_count;
    int                 pix_mode;
    int                 frame_base;

    mean_threshold_binarizer_core DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Abort a hung run
    initial begin
        #(50_000_000);
        $display("** mean_threshold_binarizer_core: FAILED **");
        $finish;
    end

    // Check each output beat on the falling edge before the edge that accepts it
    always @(negedge i_clk) begin
        if (i_rst_n && o_out_valid && !out_stall) begin
            sb.check_beat(o_out_data);
        end
    end

    // Hold off the output for a random number of cycles per beat
    initial begin
        int  hold;
        bit  fire;
        out_stall <= 1'b1;
        @(posedge i_clk);
        forever begin
            hold = idle_on ? $urandom_range(0, 10) : 0;
            if (hold > 0) begin
                out_stall <= 1'b1;
                repeat (hold) @(posedge i_clk);
            end
            out_stall <= 1'b0;
            do begin
                @(negedge i_clk);
                fire = o_out_valid && !out_stall;
                @(posedge i_clk);
            end while (!fire);
        end
    end

    task automatic send_beat(input t_in beat);
        int gap;
        bit fire;
        gap = idle_on ? $urandom_range(0, 10) : 0;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_data  <= beat;
        do begin
            @(negedge i_clk);
            fire = in_valid && !o_in_stall;
            @(posedge i_clk);
        end while (!fire);
        sb.note_beat(beat);
        beat_count++;
    endtask

    task automatic load_pixel(input logic [PIX_W-1:0] value);
        t_in beat;
        beat.action      = OP_LOAD;
        beat.pixel_value = value;
        send_beat(beat);
    endtask

    task automatic read_bit();
        t_in beat;
        beat.action      = OP_READ;
        beat.pixel_value = PIX_W'($urandom_range(0, 255));
        send_beat(beat);
    endtask

    // Drop valid, wait for every owed beat, then let the divider finish
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (sb.pending_bits.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_size(input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h);
        cfg_we   <= 1'b1;
        cfg_idx  <= CFG_FRAME_WIDTH;
        cfg_data <= w;
        @(posedge i_clk);
        sb.write_reg(CFG_FRAME_WIDTH, w);
        cfg_idx  <= CFG_FRAME_HEIGHT;
        cfg_data <= h;
        @(posedge i_clk);
        sb.write_reg(CFG_FRAME_HEIGHT, h);
        cfg_we   <= 1'b0;
    endtask

    // Mostly tiny frames; sometimes zero or oversized dimensions
    task automatic pick_size(output logic [DIM_W-1:0] w, output logic [DIM_W-1:0] h);
        int               sel;
        logic [DIM_W-1:0] swap;
        sel = $urandom_range(0, 99);
        if (sel < 70) begin
            w = DIM_W'($urandom_range(1, 6));
            h = DIM_W'($urandom_range(1, 6));
        end else if (sel < 85) begin
            w = DIM_W'($urandom_range(0, 12));
            h = DIM_W'($urandom_range(0, 2));
        end else if (sel < 97) begin
            w = DIM_W'($urandom_range(7, 16));
            h = DIM_W'($urandom_range(1, 3));
        end else begin
            w = $urandom_range(0, 1) ? DIM_W'(256) : DIM_W'($urandom_range(257, 511));
            h = DIM_W'($urandom_range(0, 1));
        end
        if ($urandom_range(0, 1)) begin
            swap = w;
            w    = h;
            h    = swap;
        end
    endtask

    function automatic logic [PIX_W-1:0] draw_pixel();
        int value;
        case (pix_mode)
            0: begin
                value = $urandom_range(0, 255);
            end
            1: begin
                value = frame_base + $urandom_range(0, 16) - 8;
                value = (value < 0) ? 0 : (value > 255) ? 255 : value;
            end
            2: begin
                value = $urandom_range(0, 1) ? 255 : 0;
            end
            default: begin
                value = frame_base;
            end
        endcase
        return PIX_W'(value);
    endfunction

    // Load until the frame closes, with optional early reads and one resize
    task automatic fill_frame(input bit noisy, input bit resize);
        int               change_at;
        int               cnt;
        logic [DIM_W-1:0] w;
        logic [DIM_W-1:0] h;
        change_at = resize ? $urandom_range(1, sb.frame_pixels()) : -1;
        cnt = 0;
        while (!sb.frame_full) begin
            if (cnt == change_at) begin
                wait_idle();
                pick_size(w, h);
                write_size(w, h);
            end
            if (noisy && $urandom_range(0, 11) == 0) begin
                read_bit();
            end
            load_pixel(draw_pixel());
            cnt++;
        end
        // Loads against a waiting frame get dropped
        if (noisy && $urandom_range(0, 3) == 0) begin
            load_pixel(draw_pixel());
        end
    endtask

    // Read the frame out, with an optional resize part way through
    task automatic empty_frame(input bit noisy, input bit resize);
        int               change_at;
        int               cnt;
        logic [DIM_W-1:0] w;
        logic [DIM_W-1:0] h;
        change_at = resize ? $urandom_range(1, sb.load_count) : -1;
        cnt = 0;
        while (sb.frame_full) begin
            if (cnt == change_at) begin
                wait_idle();
                pick_size(w, h);
                write_size(w, h);
            end
            read_bit();
            cnt++;
        end
        if (noisy && $urandom_range(0, 3) == 0) begin
            read_bit();
        end
    endtask

    initial begin
        int               start_count;
        logic [DIM_W-1:0] w;
        logic [DIM_W-1:0] h;
        sb         = new();
        idle_on    = 1'b0;
        beat_count = 0;
        pix_mode   = 0;
        frame_base = 0;
        i_rst_n  <= 1'b0;
        in_valid <= 1'b0;
        in_data  <= '0;
        cfg_we   <= 1'b0;
        cfg_idx  <= CFG_FRAME_WIDTH;
        cfg_data <= '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        // Partial frame at the reset size with bright pixels, then shrink
        // below the loaded count so the next load closes it
        read_bit();
        pix_mode   = 1;
        frame_base = 255;
        repeat (100) load_pixel(draw_pixel());
        read_bit();
        wait_idle();
        write_size(9'd8, 9'd8);
        fill_frame(1'b0, 1'b0);
        load_pixel(8'd0);
        empty_frame(1'b0, 1'b0);
        read_bit();
        wait_idle();

        // Single pixel from zero sizes; extra load dropped, read past the end
        idle_on = 1'b1;
        write_size(9'd0, 9'd0);
        load_pixel(8'd0);
        load_pixel(8'd255);
        read_bit();
        read_bit();
        wait_idle();
        write_size(9'd1, 9'd1);
        load_pixel(8'd255);
        read_bit();
        wait_idle();
        write_size(9'd2, 9'd1);
        load_pixel(8'd0);
        load_pixel(8'd255);
        read_bit();
        read_bit();
        wait_idle();

        // Shrink mid-load, then grow during readout
        write_size(9'd2, 9'd2);
        load_pixel(8'd1);
        read_bit();
        load_pixel(8'd2);
        wait_idle();
        write_size(9'd1, 9'd1);
        load_pixel(8'd3);
        read_bit();
        wait_idle();
        write_size(9'd511, 9'd511);
        read_bit();
        read_bit();
        wait_idle();

        // Oversized dimension against a zero one
        pix_mode = 0;
        write_size(9'd300, 9'd0);
        fill_frame(1'b0, 1'b0);
        empty_frame(1'b0, 1'b0);
        wait_idle();
        write_size(9'd0, 9'd511);
        fill_frame(1'b0, 1'b0);
        empty_frame(1'b0, 1'b0);
        wait_idle();

        // Random frames
        start_count = beat_count;
        while (beat_count - start_count < RANDOM_BEATS) begin
            idle_on    = ($urandom_range(0, 3) != 0);
            pix_mode   = $urandom_range(0, 3);
            frame_base = $urandom_range(0, 255);
            pick_size(w, h);
            write_size(w, h);
            fill_frame(1'b1, $urandom_range(0, 7) == 0);
            if ($urandom_range(0, 5) == 0) begin
                wait_idle();
            end
            empty_frame(1'b1, $urandom_range(0, 7) == 0);
            wait_idle();
        end

        // Drain and report
        in_valid <= 1'b0;
        while (sb.pending_bits.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending_bits.size() == 0) begin
            $display("** mean_threshold_binarizer_core: PASSED **");
        end else begin
            $display("** mean_threshold_binarizer_core: FAILED **");
        end
        $finish;
    end

endmodule
